[hw/rtl/two_line_intersection_top_defines.svh]
// Assertion macros shared by the two-line intersection RTL.
`ifndef TWO_LINE_INTERSECTION_TOP_DEFINES_SVH
`define TWO_LINE_INTERSECTION_TOP_DEFINES_SVH

// Checks that a condition holds at every clock edge out of reset.
`define TLX_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define TLX_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

[hw/rtl/tlx_pkg.sv]
// Types and constants shared by the two-line intersection modules.
package tlx_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int QUO_BITS       = 34;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_PARALLEL = 2'd1;
  localparam logic [1:0] ST_SAT      = 2'd2;

  localparam logic [QUO_BITS-1:0] MAG_MAX_POS = QUO_BITS'(32'h7FFF_FFFF);
  localparam logic [QUO_BITS-1:0] MAG_MAX_NEG = QUO_BITS'(32'h8000_0000);
  localparam logic signed [31:0]  OUT_MAX_POS = 32'sh7FFF_FFFF;
  localparam logic signed [31:0]  OUT_MAX_NEG = 32'sh8000_0000;

  typedef struct packed {
    logic [11:0] line_a_first_x;
    logic [11:0] line_a_first_y;
    logic [11:0] line_a_second_x;
    logic [11:0] line_a_second_y;
    logic [11:0] line_b_first_x;
    logic [11:0] line_b_first_y;
    logic [11:0] line_b_second_x;
    logic [11:0] line_b_second_y;
  } tlx_in_t;

  typedef struct packed {
    logic signed [31:0] cross_x;
    logic signed [31:0] cross_y;
    logic [1:0]         status;
  } tlx_out_t;

  // Per-item control that rides along the divider chain; lane 0 is x, lane 1 is y.
  typedef struct packed {
    logic       valid;
    logic       zero;
    logic [1:0] neg;
    logic [1:0] ovf;
  } tlx_ctl_t;

endpackage

[hw/rtl/tlx_front.sv]
// Front pipeline: products, determinant, numerators, magnitudes and divider setup.
module tlx_front #(
  parameter int COORD_BITS = tlx_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = tlx_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  adv,
  input  logic                                  in_valid,
  input  tlx_pkg::tlx_in_t                      in_item,
  output tlx_pkg::tlx_ctl_t                     ctl_o,
  output logic [1:0][2*COORD_BITS+2:0]          rem_o,
  output logic [1:0][tlx_pkg::QUO_BITS-1:0]     lq_o,
  output logic [2*COORD_BITS+2:0]               den_o
);

  localparam int C   = COORD_BITS;
  localparam int QB  = tlx_pkg::QUO_BITS;
  localparam int DW  = 2*C + 3;
  localparam int NW  = 3*C + 3;
  localparam int TW  = NW + FRAC_BITS + 1;
  localparam int NPW = (TW > QB) ? TW : QB + 1;
  localparam int HW  = NPW - QB;
  localparam int CW  = (HW > DW) ? HW : DW;

  // Stage 1: coordinates.
  logic [C-1:0] ax1_r, ay1_r, ax2_r, ay2_r, bx1_r, by1_r, bx2_r, by2_r;
  logic         v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax1_r <= C'(in_item.line_a_first_x);
      ay1_r <= C'(in_item.line_a_first_y);
      ax2_r <= C'(in_item.line_a_second_x);
      ay2_r <= C'(in_item.line_a_second_y);
      bx1_r <= C'(in_item.line_b_first_x);
      by1_r <= C'(in_item.line_b_first_y);
      bx2_r <= C'(in_item.line_b_second_x);
      by2_r <= C'(in_item.line_b_second_y);
    end
  end

  // Stage 2: differences and the six first-level products.
  logic signed [C:0] adx_nxt, ady_nxt, bdx_nxt, bdy_nxt;
  logic signed [C:0] adx_r, ady_r, bdx_r, bdy_r;
  logic signed [2*C+1:0] pab_r, pba_r;
  logic [2*C-1:0] pca1_r, pca2_r, pcb1_r, pcb2_r;
  logic v2_r;

  assign adx_nxt = $signed({1'b0, ax1_r}) - $signed({1'b0, ax2_r});
  assign ady_nxt = $signed({1'b0, ay1_r}) - $signed({1'b0, ay2_r});
  assign bdx_nxt = $signed({1'b0, bx1_r}) - $signed({1'b0, bx2_r});
  assign bdy_nxt = $signed({1'b0, by1_r}) - $signed({1'b0, by2_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      adx_r  <= adx_nxt;
      ady_r  <= ady_nxt;
      bdx_r  <= bdx_nxt;
      bdy_r  <= bdy_nxt;
      pab_r  <= adx_nxt * bdy_nxt;
      pba_r  <= ady_nxt * bdx_nxt;
      pca1_r <= ax1_r * ay2_r;
      pca2_r <= ay1_r * ax2_r;
      pcb1_r <= bx1_r * by2_r;
      pcb2_r <= by1_r * bx2_r;
    end
  end

  // Stage 3: determinant and the two line constants.
  logic signed [DW-1:0]  den3_r;
  logic signed [2*C:0]   ca_r, cb_r;
  logic signed [C:0]     adx3_r, ady3_r, bdx3_r, bdy3_r;
  logic v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      den3_r <= DW'(pab_r) - DW'(pba_r);
      ca_r   <= $signed({1'b0, pca1_r}) - $signed({1'b0, pca2_r});
      cb_r   <= $signed({1'b0, pcb1_r}) - $signed({1'b0, pcb2_r});
      adx3_r <= adx_r;
      ady3_r <= ady_r;
      bdx3_r <= bdx_r;
      bdy3_r <= bdy_r;
    end
  end

  // Stage 4: numerator products.
  logic signed [3*C+1:0] px1_r, px2_r, py1_r, py2_r;
  logic signed [DW-1:0]  den4_r;
  logic v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px1_r  <= ca_r * bdx3_r;
      px2_r  <= adx3_r * cb_r;
      py1_r  <= ca_r * bdy3_r;
      py2_r  <= ady3_r * cb_r;
      den4_r <= den3_r;
    end
  end

  // Stage 5: numerators.
  logic signed [NW-1:0] nx_r, ny_r;
  logic signed [DW-1:0] den5_r;
  logic v5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (adv) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nx_r   <= NW'(px1_r) - NW'(px2_r);
      ny_r   <= NW'(py1_r) - NW'(py2_r);
      den5_r <= den4_r;
    end
  end

  // Stage 6: magnitudes and result signs.
  logic [1:0][NW-1:0] nmag_r;
  logic [DW-1:0]      dmag_r;
  logic [1:0]         neg6_r;
  logic               zero6_r;
  logic               v6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (adv) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nmag_r[0] <= nx_r[NW-1] ? NW'(-nx_r) : NW'(nx_r);
      nmag_r[1] <= ny_r[NW-1] ? NW'(-ny_r) : NW'(ny_r);
      dmag_r    <= den5_r[DW-1] ? DW'(-den5_r) : DW'(den5_r);
      neg6_r[0] <= nx_r[NW-1] ^ den5_r[DW-1];
      neg6_r[1] <= ny_r[NW-1] ^ den5_r[DW-1];
      zero6_r   <= (den5_r == '0);
    end
  end

  // Stage 7: scale by 2^(FRAC_BITS+1), split off the part above the quotient
  // bits and flag lanes whose quotient cannot fit.
  logic [1:0][NPW-1:0] ndiv;
  logic [1:0][HW-1:0]  nhi;
  logic [1:0]          ovf_nxt;
  tlx_pkg::tlx_ctl_t   ctl_r;
  logic [1:0][DW-1:0]  rem_r;
  logic [1:0][QB-1:0]  lq_r;
  logic [DW-1:0]       den_r;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      ndiv[i]    = NPW'({nmag_r[i], {(FRAC_BITS+1){1'b0}}});
      nhi[i]     = ndiv[i][NPW-1:QB];
      ovf_nxt[i] = CW'(nhi[i]) >= CW'(dmag_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r.valid <= v6_r;
      ctl_r.zero  <= zero6_r;
      ctl_r.neg   <= neg6_r;
      ctl_r.ovf   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 2; i++) begin
        rem_r[i] <= DW'(nhi[i]);
        lq_r[i]  <= ndiv[i][QB-1:0];
      end
      den_r <= dmag_r;
    end
  end

  assign ctl_o = ctl_r;
  assign rem_o = rem_r;
  assign lq_o  = lq_r;
  assign den_o = den_r;

endmodule

[hw/rtl/tlx_cell.sv]
// One restoring-division cell: produces one quotient bit per lane and passes the item on.
module tlx_cell #(
  parameter int COORD_BITS = tlx_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               adv,
  input  tlx_pkg::tlx_ctl_t                  ctl_i,
  input  logic [1:0][2*COORD_BITS+2:0]       rem_i,
  input  logic [1:0][tlx_pkg::QUO_BITS-1:0]  lq_i,
  input  logic [2*COORD_BITS+2:0]            den_i,
  output tlx_pkg::tlx_ctl_t                  ctl_o,
  output logic [1:0][2*COORD_BITS+2:0]       rem_o,
  output logic [1:0][tlx_pkg::QUO_BITS-1:0]  lq_o,
  output logic [2*COORD_BITS+2:0]            den_o
);

  localparam int DW = 2*COORD_BITS + 3;
  localparam int QB = tlx_pkg::QUO_BITS;

  logic [1:0][DW:0]    trial;
  logic [1:0]          qbit;
  logic [1:0][DW-1:0]  rem_nxt;
  logic [1:0][QB-1:0]  lq_nxt;
  tlx_pkg::tlx_ctl_t   ctl_r;
  logic [1:0][DW-1:0]  rem_r;
  logic [1:0][QB-1:0]  lq_r;
  logic [DW-1:0]       den_r;

  // The next dividend bit leaves from the top of lq while the quotient bit fills its bottom.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      trial[i]   = {rem_i[i], lq_i[i][QB-1]};
      qbit[i]    = trial[i] >= {1'b0, den_i};
      rem_nxt[i] = qbit[i] ? DW'(trial[i] - {1'b0, den_i}) : DW'(trial[i]);
      lq_nxt[i]  = {lq_i[i][QB-2:0], qbit[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r <= rem_nxt;
      lq_r  <= lq_nxt;
      den_r <= den_i;
    end
  end

  assign ctl_o = ctl_r;
  assign rem_o = rem_r;
  assign lq_o  = lq_r;
  assign den_o = den_r;

endmodule

[hw/rtl/two_line_intersection_top.sv]
// Pipeline: 7 front stages, 34 divider cells, 1 output register.
// Throughput: one item per cycle; the whole pipeline holds only while a result waits under out_stall.
// Each divider cell resolves one quotient bit for x and y, so the 34-cell chain sets the latency.
// Reset (rst_n low, synchronous) empties the pipeline and drops out_valid; no data is cleared.
`include "two_line_intersection_top_defines.svh"

module two_line_intersection_top #(
  parameter int COORD_BITS = tlx_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = tlx_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tlx_pkg::tlx_in_t   in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output tlx_pkg::tlx_out_t  out_item
);

  localparam int DW = 2*COORD_BITS + 3;
  localparam int QB = tlx_pkg::QUO_BITS;

  logic adv;
  logic out_valid_r;
  tlx_pkg::tlx_out_t out_item_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  tlx_pkg::tlx_ctl_t   ctl_ch [QB+1];
  logic [1:0][DW-1:0]  rem_ch [QB+1];
  logic [1:0][QB-1:0]  lq_ch  [QB+1];
  logic [DW-1:0]       den_ch [QB+1];

  tlx_front #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_valid),
    .in_item  (in_item),
    .ctl_o    (ctl_ch[0]),
    .rem_o    (rem_ch[0]),
    .lq_o     (lq_ch[0]),
    .den_o    (den_ch[0])
  );

  for (genvar k = 0; k < QB; k++) begin : g_cell
    tlx_cell #(
      .COORD_BITS (COORD_BITS)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .ctl_i (ctl_ch[k]),
      .rem_i (rem_ch[k]),
      .lq_i  (lq_ch[k]),
      .den_i (den_ch[k]),
      .ctl_o (ctl_ch[k+1]),
      .rem_o (rem_ch[k+1]),
      .lq_o  (lq_ch[k+1]),
      .den_o (den_ch[k+1])
    );
  end

  // Round half away from zero: the chain delivers floor(2 * 2^F * n / d), so add one and halve.
  tlx_pkg::tlx_ctl_t         ctl_end;
  logic [1:0][QB:0]          mag_inc;
  logic [1:0][QB-1:0]        mag;
  logic [1:0][QB-1:0]        limit;
  logic [1:0]                sat;
  logic signed [1:0][31:0]   coord_val;
  tlx_pkg::tlx_out_t         out_item_nxt;

  assign ctl_end = ctl_ch[QB];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      mag_inc[i] = {1'b0, lq_ch[QB][i]} + (QB+1)'(1);
      mag[i]     = mag_inc[i][QB:1];
      limit[i]   = ctl_end.neg[i] ? tlx_pkg::MAG_MAX_NEG : tlx_pkg::MAG_MAX_POS;
      sat[i]     = ctl_end.ovf[i] || (mag[i] > limit[i]);
      if (sat[i]) begin
        coord_val[i] = ctl_end.neg[i] ? tlx_pkg::OUT_MAX_NEG : tlx_pkg::OUT_MAX_POS;
      end else begin
        coord_val[i] = ctl_end.neg[i] ? -$signed(mag[i][31:0]) : $signed(mag[i][31:0]);
      end
    end
    if (ctl_end.zero) begin
      out_item_nxt.cross_x = '0;
      out_item_nxt.cross_y = '0;
      out_item_nxt.status  = tlx_pkg::ST_PARALLEL;
    end else begin
      out_item_nxt.cross_x = coord_val[0];
      out_item_nxt.cross_y = coord_val[1];
      out_item_nxt.status  = (sat != 2'b00) ? tlx_pkg::ST_SAT : tlx_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ctl_end.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ctl_end.valid) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `TLX_ASSERT(a_parallel_zero, !(out_valid_r && out_item_r.status == tlx_pkg::ST_PARALLEL) || (out_item_r.cross_x == '0 && out_item_r.cross_y == '0), "parallel result has nonzero coordinates")
  `TLX_ASSERT(a_status_code, !out_valid_r || out_item_r.status != 2'd3, "undefined status code")
  `TLX_ASSERT(a_sat_clamped, !(out_valid_r && out_item_r.status == tlx_pkg::ST_SAT) || out_item_r.cross_x == tlx_pkg::OUT_MAX_POS || out_item_r.cross_x == tlx_pkg::OUT_MAX_NEG || out_item_r.cross_y == tlx_pkg::OUT_MAX_POS || out_item_r.cross_y == tlx_pkg::OUT_MAX_NEG, "saturated result without a clamped coordinate")
  `TLX_ASSERT_NEXT(a_hold_stalled, out_valid_r && out_stall, out_valid_r && $stable(ctl_ch[QB]), "pipeline moved while the output item was stalled")

endmodule
